// File: rtl/olad_pkg.sv
// ----------------------------------------------------------------------------
// olad_pkg
// Shared types, codes and the microcode table of the ordered list store.
// ----------------------------------------------------------------------------
`default_nettype none

package olad_pkg;

	// Command codes
	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// Microprogram step addresses
	localparam int PcW = 5;
	localparam logic [PcW-1:0] S_IDLE     = 5'd0;
	localparam logic [PcW-1:0] S_APP      = 5'd1;
	localparam logic [PcW-1:0] S_APP_WR   = 5'd2;
	localparam logic [PcW-1:0] S_DEL      = 5'd3;
	localparam logic [PcW-1:0] S_DEL_RD   = 5'd4;
	localparam logic [PcW-1:0] S_DEL_CMP  = 5'd5;
	localparam logic [PcW-1:0] S_DEL_NXT  = 5'd6;
	localparam logic [PcW-1:0] S_CMP_CHK  = 5'd7;
	localparam logic [PcW-1:0] S_CMP_RD   = 5'd8;
	localparam logic [PcW-1:0] S_CMP_WR   = 5'd9;
	localparam logic [PcW-1:0] S_DEL_DONE = 5'd10;
	localparam logic [PcW-1:0] S_RD       = 5'd11;
	localparam logic [PcW-1:0] S_RD_RD    = 5'd12;
	localparam logic [PcW-1:0] S_RD_EMIT  = 5'd13;
	localparam logic [PcW-1:0] S_EM_FULL  = 5'd14;
	localparam logic [PcW-1:0] S_EM_NF    = 5'd15;
	localparam logic [PcW-1:0] S_EM_EMPTY = 5'd16;

	// Jump conditions
	localparam logic [2:0] C_ALWAYS = 3'd0;
	localparam logic [2:0] C_DISP   = 3'd1;
	localparam logic [2:0] C_FULL   = 3'd2;
	localparam logic [2:0] C_ZERO   = 3'd3;
	localparam logic [2:0] C_MATCH  = 3'd4;
	localparam logic [2:0] C_LAST   = 3'd5;

	typedef struct packed {
		logic [1:0]        cmd;
		logic signed [31:0] value;
	} item_t;

	typedef struct packed {
		logic signed [31:0] data;
		logic [1:0]         status;
		logic               last;
	} result_t;

	// One control word
	typedef struct packed {
		logic [2:0]     cond;
		logic [PcW-1:0] tgt_t;
		logic [PcW-1:0] tgt_f;
		logic           rdy;        // take a transaction on the item channel
		logic           idx_clr;
		logic           idx_inc;
		logic           rd;         // read the store
		logic           rd_next;    // read address idx+1 rather than idx
		logic           wr;         // write the store
		logic           wr_at_idx;  // write address idx rather than count
		logic           wr_rdata;   // write read data rather than item value
		logic           cnt_inc;
		logic           cnt_dec;
		logic           emit;       // load a result
		logic           emit_rdata; // result data from read data, else zero
		logic [1:0]     status;
		logic           last_eval;  // last flag from index compare, else one
	} ucode_t;

	// Status and control flags seen by the sequencer
	typedef struct packed {
		logic       accept;
		logic [1:0] cmd;
		logic       full;
		logic       zero;
		logic       match;
		logic       last;
		logic       out_free;
	} flags_t;

	// Entry step for each command; an unused code returns to idle
	function automatic logic [PcW-1:0] dispatch(input logic [1:0] cmd);
		logic [PcW-1:0] t;
		unique case (cmd)
			CMD_APPEND: t = S_APP;
			CMD_DELETE: t = S_DEL;
			CMD_READ:   t = S_RD;
			default:    t = S_IDLE;
		endcase
		return t;
	endfunction

	// Microcode ROM
	function automatic ucode_t ucode(input logic [PcW-1:0] pc);
		ucode_t w;
		w = '0;
		w.cond  = C_ALWAYS;
		w.tgt_t = S_IDLE;
		w.tgt_f = S_IDLE;
		unique case (pc)
			S_IDLE: begin
				w.rdy = 1'b1; w.idx_clr = 1'b1;
				w.cond = C_DISP; w.tgt_f = S_IDLE;
			end
			S_APP: begin
				w.cond = C_FULL; w.tgt_t = S_EM_FULL; w.tgt_f = S_APP_WR;
			end
			S_APP_WR: begin
				w.wr = 1'b1; w.cnt_inc = 1'b1;
				w.emit = 1'b1; w.status = ST_OK;
			end
			S_DEL: begin
				w.cond = C_ZERO; w.tgt_t = S_EM_EMPTY; w.tgt_f = S_DEL_RD;
			end
			S_DEL_RD: begin
				w.rd = 1'b1; w.tgt_t = S_DEL_CMP;
			end
			S_DEL_CMP: begin
				w.cond = C_MATCH; w.tgt_t = S_CMP_CHK; w.tgt_f = S_DEL_NXT;
			end
			S_DEL_NXT: begin
				w.idx_inc = 1'b1;
				w.cond = C_LAST; w.tgt_t = S_EM_NF; w.tgt_f = S_DEL_RD;
			end
			S_CMP_CHK: begin
				w.cond = C_LAST; w.tgt_t = S_DEL_DONE; w.tgt_f = S_CMP_RD;
			end
			S_CMP_RD: begin
				w.rd = 1'b1; w.rd_next = 1'b1; w.tgt_t = S_CMP_WR;
			end
			S_CMP_WR: begin
				w.wr = 1'b1; w.wr_at_idx = 1'b1; w.wr_rdata = 1'b1;
				w.idx_inc = 1'b1; w.tgt_t = S_CMP_CHK;
			end
			S_DEL_DONE: begin
				w.cnt_dec = 1'b1; w.emit = 1'b1; w.status = ST_OK;
			end
			S_RD: begin
				w.cond = C_ZERO; w.tgt_t = S_EM_EMPTY; w.tgt_f = S_RD_RD;
			end
			S_RD_RD: begin
				w.rd = 1'b1; w.tgt_t = S_RD_EMIT;
			end
			S_RD_EMIT: begin
				w.emit = 1'b1; w.emit_rdata = 1'b1; w.status = ST_OK;
				w.last_eval = 1'b1; w.idx_inc = 1'b1;
				w.cond = C_LAST; w.tgt_t = S_IDLE; w.tgt_f = S_RD_RD;
			end
			S_EM_FULL: begin
				w.emit = 1'b1; w.status = ST_FULL;
			end
			S_EM_NF: begin
				w.emit = 1'b1; w.status = ST_NOT_FOUND;
			end
			S_EM_EMPTY: begin
				w.emit = 1'b1; w.status = ST_EMPTY;
			end
			default: begin
				w.tgt_t = S_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// File: rtl/olad_seq.sv
// ----------------------------------------------------------------------------
// olad_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module olad_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire olad_pkg::flags_t flags,
	output olad_pkg::ucode_t     ctl,
	output logic                 go
);

	logic [olad_pkg::PcW-1:0] pc_q;
	logic [olad_pkg::PcW-1:0] pc_next;
	logic                     cond_hit;

	// current control word
	assign ctl = olad_pkg::ucode(pc_q);

	// a result step holds until the output register has room
	assign go = !(ctl.emit && !flags.out_free);

	// condition select
	always_comb begin
		unique case (ctl.cond)
			olad_pkg::C_ALWAYS: cond_hit = 1'b1;
			olad_pkg::C_DISP:   cond_hit = flags.accept;
			olad_pkg::C_FULL:   cond_hit = flags.full;
			olad_pkg::C_ZERO:   cond_hit = flags.zero;
			olad_pkg::C_MATCH:  cond_hit = flags.match;
			olad_pkg::C_LAST:   cond_hit = flags.last;
			default:            cond_hit = 1'b1;
		endcase
	end

	// next step
	always_comb begin
		if (!go) begin
			pc_next = pc_q;
		end else if (ctl.cond == olad_pkg::C_DISP) begin
			pc_next = cond_hit ? olad_pkg::dispatch(flags.cmd) : ctl.tgt_f;
		end else begin
			pc_next = cond_hit ? ctl.tgt_t : ctl.tgt_f;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= olad_pkg::S_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

`default_nettype wire

// File: rtl/ordered_list_append_delete.sv
// ----------------------------------------------------------------------------
// ordered_list_append_delete
// Ordered list of signed 32-bit values: append at tail, delete first match
// with compaction, and read out head to tail. Microcoded control.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  item      in         item_valid / item_stall    olad_pkg::item_t   {cmd, value}
//  result    out        result_valid/result_stall  olad_pkg::result_t {data,status,last}
//
//  One item at a time: append checks for a full store, then writes at the
//  tail; delete reads and compares each entry from the head, and on a match
//  moves each later entry down one place before the result; readout reads
//  and emits each entry in turn. The store has a single port with a
//  registered read.
//  Reset clears the list length; the store itself is not cleared.
//  A stalled result holds the sequencer at its result step; the next item
//  is taken while the last result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_append_delete #(
	parameter int DEPTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire olad_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output olad_pkg::result_t      result
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	olad_pkg::ucode_t ctl;
	olad_pkg::flags_t flags;
	logic             go;
	logic             accept;
	logic             out_free;
	logic             last_hit;

	olad_pkg::item_t   item_q;
	olad_pkg::result_t out_q;
	logic              out_valid_q;
	logic [CW-1:0]     count_q;
	logic [IW-1:0]     idx_q;
	logic [31:0]       rdata_q;
	logic [31:0]       mem [DEPTH];

	logic [IW-1:0]     raddr;
	logic [IW-1:0]     waddr;
	logic [31:0]       wdata;

	// handshake
	assign item_stall   = !ctl.rdy;
	assign accept       = item_valid && !item_stall;
	assign out_free     = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	assign last_hit = (CW'(idx_q) + CW'(1)) == count_q;

	// flags for the sequencer
	always_comb begin
		flags.accept   = accept;
		flags.cmd      = item.cmd;
		flags.full     = count_q == CW'(DEPTH);
		flags.zero     = count_q == '0;
		flags.match    = rdata_q == item_q.value;
		flags.last     = last_hit;
		flags.out_free = out_free;
	end

	olad_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl),
		.go     (go)
	);

	// store addresses and write data
	assign raddr = ctl.rd_next ? IW'(CW'(idx_q) + CW'(1)) : idx_q;
	assign waddr = ctl.wr_at_idx ? idx_q : count_q[IW-1:0];
	assign wdata = ctl.wr_rdata ? rdata_q : item_q.value;

	// item register
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
	end

	// list store with registered read
	always_ff @(posedge clk) begin
		if (go && ctl.wr) begin
			mem[waddr] <= wdata;
		end
		if (go && ctl.rd) begin
			rdata_q <= mem[raddr];
		end
	end

	// length and walk index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else if (go) begin
			if (ctl.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (ctl.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (ctl.idx_clr) begin
				idx_q <= '0;
			end else if (ctl.idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (go && ctl.emit) begin
			out_q.data   <= ctl.emit_rdata ? rdata_q : '0;
			out_q.status <= ctl.status;
			out_q.last   <= ctl.last_eval ? last_hit : 1'b1;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	// list length never passes the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("list length beyond depth");

	// length moves by at most one per step
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |->
			(count_q == $past(count_q) + CW'(1)) || (count_q == $past(count_q) - CW'(1)))
		else $error("list length jumped");

	// only readout produces non-final results, and those are ok
	a_nonlast_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> result.status == olad_pkg::ST_OK)
		else $error("non-final result with error status");

	// a result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(out_q))
		else $error("waiting result overwritten");
`endif

endmodule

`default_nettype wire
